@@ src/asa_pkg.sv @@
// shared types, codes and defaults of the aligned stack allocator
`timescale 1ns / 1ps
`default_nettype none

package asa_pkg;

    // fixed port widths
    localparam int ADDR_PORT_W = 64;
    localparam int SIZE_PORT_W = 32;
    localparam int APB_DATA_W  = 64;
    localparam int APB_ADDR_W  = 4;

    // parameter defaults
    localparam int SIZE_BITS_DEF = 32;
    localparam int ADDR_BITS_DEF = 64;

    // command codes
    localparam logic [1:0] CMD_ALLOC = 2'd0;
    localparam logic [1:0] CMD_FREE  = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;
    localparam logic [1:0] CMD_QUERY = 2'd3;

    // status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOSPACE   = 2'd1;
    localparam logic [1:0] ST_ZEROALIGN = 2'd2;
    localparam logic [1:0] ST_BADMARK   = 2'd3;

    // register indexes, selected by paddr[3]
    localparam logic REG_BASE = 1'b0;
    localparam logic REG_CAP  = 1'b1;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load_item;
        logic load_top;
        logic div_step;
        logic make_pad;
        logic commit;
    } asa_ctl_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic need_div;
    } asa_sts_t;

endpackage

`default_nettype wire

@@ src/aligned_stack_allocator.sv @@
// top level of the aligned stack allocator
`timescale 1ns / 1ps
`default_nettype none

// bump-pointer stack allocator over the region [base_address, base_address + capacity)
// input channel: in_valid / in_stall carry one command beat (cmd, size_bytes,
//   align_bytes, target_marker); a beat is taken when in_valid is high and in_stall low
// output channel: out_valid / out_stall carry one result beat per command
//   (status, address, used_bytes, unused_bytes)
// config: apb-style port, base_address at 0x0 and capacity_bytes at 0x8, 64-bit data,
//   pready tied high; write config only while no command is in flight
// sequence: a command beat is taken in idle and the top address is loaded; an allocate
//   with nonzero alignment then runs the remainder steps and the pad step, which free,
//   clear, query and zero-alignment allocate skip; a new command is taken only in idle;
//   the top address modulo the alignment comes from a radix-2 restoring
//   remainder unit that handles one address bit per cycle
// in_stall is high from the cycle after a beat is taken until the result is
//   written into the output register
// the output register lets a new command start while a result waits; if the
//   receiver stalls, the finished result of the next command holds in the
//   controller until the output register is free
// reset: marker, base and capacity clear to zero, both channels go idle
// address is zero for every result other than a successful allocate

module aligned_stack_allocator
    import asa_pkg::*;
#(
    parameter int SIZE_BITS = SIZE_BITS_DEF,
    parameter int ADDR_BITS = ADDR_BITS_DEF
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    // apb config port
    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [APB_ADDR_W-1:0]  paddr,
    input  wire logic [APB_DATA_W-1:0]  pwdata,
    output logic [APB_DATA_W-1:0]       prdata,
    output logic                        pready,
    // command channel
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire logic [1:0]             cmd,
    input  wire logic [SIZE_PORT_W-1:0] size_bytes,
    input  wire logic [SIZE_PORT_W-1:0] align_bytes,
    input  wire logic [SIZE_PORT_W-1:0] target_marker,
    // result channel
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output logic [1:0]                  status,
    output logic [ADDR_PORT_W-1:0]      address,
    output logic [SIZE_PORT_W-1:0]      used_bytes,
    output logic [SIZE_PORT_W-1:0]      unused_bytes
);

    asa_ctl_t             ctl;
    asa_sts_t             sts;
    logic                 cfg_write;
    logic                 cfg_we_base;
    logic                 cfg_we_cap;
    logic [ADDR_BITS-1:0] base_q;
    logic [SIZE_BITS-1:0] cap_q;

    // register write strobe, register chosen by paddr[3]
    assign pready      = 1'b1;
    assign cfg_write   = psel && penable && pwrite && pready;
    assign cfg_we_base = cfg_write && (paddr[3] == REG_BASE);
    assign cfg_we_cap  = cfg_write && (paddr[3] == REG_CAP);

    // read back
    always_comb
    begin
        unique case (paddr[3])
            REG_BASE: prdata = APB_DATA_W'(base_q);
            REG_CAP:  prdata = APB_DATA_W'(cap_q);
        endcase
    end

    asa_ctrl #(
        .ADDR_BITS (ADDR_BITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .sts       (sts),
        .ctl       (ctl)
    );

    asa_dp #(
        .SIZE_BITS (SIZE_BITS),
        .ADDR_BITS (ADDR_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctl           (ctl),
        .sts           (sts),
        .cmd           (cmd),
        .size_bytes    (size_bytes),
        .align_bytes   (align_bytes),
        .target_marker (target_marker),
        .cfg_we_base   (cfg_we_base),
        .cfg_we_cap    (cfg_we_cap),
        .cfg_wdata     (pwdata),
        .base_q        (base_q),
        .cap_q         (cap_q),
        .status        (status),
        .address       (address),
        .used_bytes    (used_bytes),
        .unused_bytes  (unused_bytes)
    );

endmodule

`default_nettype wire

@@ src/asa_ctrl.sv @@
// controller state machine of the aligned stack allocator
`timescale 1ns / 1ps
`default_nettype none

module asa_ctrl
    import asa_pkg::*;
#(
    parameter int ADDR_BITS = ADDR_BITS_DEF
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_stall,
    input  wire logic     out_stall,
    output logic          out_valid,
    input  wire asa_sts_t sts,
    output asa_ctl_t      ctl
);

    localparam int CNT_W = $clog2(ADDR_BITS);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_TOP  = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_PAD  = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0]       state_reg;
    logic [2:0]       state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             out_free;

    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        ctl        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    ctl.load_item = 1'b1;
                    state_next    = S_TOP;
                end
            end
            S_TOP:
            begin
                ctl.load_top = 1'b1;
                cnt_next     = CNT_W'(ADDR_BITS - 1);
                state_next   = sts.need_div ? S_DIV : S_DONE;
            end
            S_DIV:
            begin
                ctl.div_step = 1'b1;
                cnt_next     = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    state_next = S_PAD;
                end
            end
            S_PAD:
            begin
                ctl.make_pad = 1'b1;
                state_next   = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    ctl.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (ctl.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

@@ src/asa_dp.sv @@
// datapath of the aligned stack allocator: registers, remainder unit, result logic
`timescale 1ns / 1ps
`default_nettype none

module asa_dp
    import asa_pkg::*;
#(
    parameter int SIZE_BITS = SIZE_BITS_DEF,
    parameter int ADDR_BITS = ADDR_BITS_DEF
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire asa_ctl_t               ctl,
    output asa_sts_t                    sts,
    input  wire logic [1:0]             cmd,
    input  wire logic [SIZE_PORT_W-1:0] size_bytes,
    input  wire logic [SIZE_PORT_W-1:0] align_bytes,
    input  wire logic [SIZE_PORT_W-1:0] target_marker,
    input  wire logic                   cfg_we_base,
    input  wire logic                   cfg_we_cap,
    input  wire logic [APB_DATA_W-1:0]  cfg_wdata,
    output logic [ADDR_BITS-1:0]        base_q,
    output logic [SIZE_BITS-1:0]        cap_q,
    output logic [1:0]                  status,
    output logic [ADDR_PORT_W-1:0]      address,
    output logic [SIZE_PORT_W-1:0]      used_bytes,
    output logic [SIZE_PORT_W-1:0]      unused_bytes
);

    localparam int WIDE = (ADDR_BITS > SIZE_BITS) ? ADDR_BITS : SIZE_BITS;

    // item and configuration
    logic [1:0]           cmd_reg;
    logic [SIZE_BITS-1:0] size_reg;
    logic [SIZE_BITS-1:0] align_reg;
    logic [SIZE_BITS-1:0] target_reg;
    logic [ADDR_BITS-1:0] base_reg;
    logic [SIZE_BITS-1:0] cap_reg;
    logic [SIZE_BITS-1:0] marker_reg;
    logic [SIZE_BITS-1:0] marker_next;

    // remainder unit
    logic [ADDR_BITS-1:0] top_reg;
    logic [ADDR_BITS-1:0] shf_reg;
    logic [SIZE_BITS-1:0] rem_reg;
    logic [SIZE_BITS-1:0] rem_next;
    logic [SIZE_BITS:0]   trial;
    logic [SIZE_BITS:0]   trial_diff;
    logic [WIDE-1:0]      top_sum;

    // padding and placement
    logic [SIZE_BITS-1:0] pad;
    logic [SIZE_BITS:0]   eff_reg;
    logic [ADDR_BITS-1:0] addr_reg;
    logic [WIDE-1:0]      addr_sum;
    logic [SIZE_BITS+1:0] end_sum;

    // result
    logic [1:0]           status_next;
    logic [ADDR_BITS-1:0] address_next;
    logic [SIZE_BITS-1:0] unused_next;
    logic [1:0]           status_reg;
    logic [ADDR_BITS-1:0] address_reg;
    logic [SIZE_BITS-1:0] used_reg;
    logic [SIZE_BITS-1:0] unused_reg;

    assign sts.need_div = (cmd_reg == CMD_ALLOC) && (align_reg != '0);
    assign base_q       = base_reg;
    assign cap_q        = cap_reg;

    // top address wraps at the address width
    assign top_sum = WIDE'(base_reg) + WIDE'(marker_reg);

    // one restoring remainder step per cycle, msb of the top first
    assign trial      = {rem_reg, shf_reg[ADDR_BITS-1]};
    assign trial_diff = trial - {1'b0, align_reg};
    assign rem_next   = (trial >= {1'b0, align_reg}) ? trial_diff[SIZE_BITS-1:0]
                                                      : trial[SIZE_BITS-1:0];

    assign pad      = (rem_reg == '0) ? '0 : (align_reg - rem_reg);
    assign addr_sum = WIDE'(top_reg) + WIDE'(pad);
    assign end_sum  = (SIZE_BITS+2)'(marker_reg) + (SIZE_BITS+2)'(eff_reg);

    always_comb
    begin
        status_next  = ST_OK;
        address_next = '0;
        marker_next  = marker_reg;
        unique case (cmd_reg)
            CMD_ALLOC:
            begin
                if (align_reg == '0)
                begin
                    status_next = ST_ZEROALIGN;
                end
                else if (end_sum > (SIZE_BITS+2)'(cap_reg))
                begin
                    status_next = ST_NOSPACE;
                end
                else
                begin
                    marker_next  = end_sum[SIZE_BITS-1:0];
                    address_next = addr_reg;
                end
            end
            CMD_FREE:
            begin
                if (target_reg <= cap_reg)
                begin
                    marker_next = target_reg;
                end
                else
                begin
                    status_next = ST_BADMARK;
                end
            end
            CMD_CLEAR:
            begin
                marker_next = '0;
            end
            CMD_QUERY:
            begin
                marker_next = marker_reg;
            end
        endcase
    end

    assign unused_next = (cap_reg > marker_next) ? (cap_reg - marker_next) : '0;

    // state and configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg   <= '0;
            cap_reg    <= '0;
            marker_reg <= '0;
        end
        else
        begin
            if (cfg_we_base)
            begin
                base_reg <= cfg_wdata[ADDR_BITS-1:0];
            end
            if (cfg_we_cap)
            begin
                cap_reg <= cfg_wdata[SIZE_BITS-1:0];
            end
            if (ctl.commit)
            begin
                marker_reg <= marker_next;
            end
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        if (ctl.load_item)
        begin
            cmd_reg    <= cmd;
            size_reg   <= size_bytes[SIZE_BITS-1:0];
            align_reg  <= align_bytes[SIZE_BITS-1:0];
            target_reg <= target_marker[SIZE_BITS-1:0];
        end
        if (ctl.load_top)
        begin
            top_reg <= top_sum[ADDR_BITS-1:0];
            shf_reg <= top_sum[ADDR_BITS-1:0];
            rem_reg <= '0;
        end
        if (ctl.div_step)
        begin
            shf_reg <= {shf_reg[ADDR_BITS-2:0], 1'b0};
            rem_reg <= rem_next;
        end
        if (ctl.make_pad)
        begin
            eff_reg  <= {1'b0, size_reg} + {1'b0, pad};
            addr_reg <= addr_sum[ADDR_BITS-1:0];
        end
        if (ctl.commit)
        begin
            status_reg  <= status_next;
            address_reg <= address_next;
            used_reg    <= marker_next;
            unused_reg  <= unused_next;
        end
    end

    assign status       = status_reg;
    assign address      = ADDR_PORT_W'(address_reg);
    assign used_bytes   = SIZE_PORT_W'(used_reg);
    assign unused_bytes = SIZE_PORT_W'(unused_reg);

endmodule

`default_nettype wire

@@ src/asa_checker.sv @@
// port-level checks of the aligned stack allocator and their bind
`timescale 1ns / 1ps
`default_nettype none

module asa_checker
    import asa_pkg::*;
(
    input wire logic                   clk,
    input wire logic                   rst_n,
    input wire logic                   in_valid,
    input wire logic                   in_stall,
    input wire logic                   out_valid,
    input wire logic                   out_stall,
    input wire logic [1:0]             status,
    input wire logic [ADDR_PORT_W-1:0] address,
    input wire logic [SIZE_PORT_W-1:0] used_bytes
);

    // one command at a time: busy right after a beat is taken
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("command taken while the previous one is in flight");

    // no result can show up in the cycle right after a beat is taken
    a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> !$rose(out_valid))
        else $error("result appeared too early");

    // results with a status other than ok carry a zero address
    a_addr_zero_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != ST_OK) |-> (address == '0))
        else $error("nonzero address on a failed command");

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=>
            out_valid && $stable(status) && $stable(address) && $stable(used_bytes))
        else $error("stalled result beat changed");

endmodule

bind aligned_stack_allocator asa_checker u_asa_checker (.*);

`default_nettype wire
